// ===== src/hdtc_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the heading turn controller.
`timescale 1ns / 1ps

package hdtc_pkg;

  localparam int CORDIC_STEPS = 14;
  localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int MUL_LAST     = 4;
  localparam int CNT_W        = (STEP_W > 3) ? STEP_W : 3;

  localparam int QW      = 16;
  localparam int PROD_W  = 32;
  localparam int ACC_W   = 33;
  localparam int XW      = 37;
  localparam int ANG_W   = 32;
  localparam int HD_W    = 16;
  localparam int TOL_W   = 15;
  localparam int RATE_W  = 10;
  localparam int ORATE_W = 11;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;

  localparam logic [HD_W-1:0]   TURN_ANGLE_RST = 16'd32768;
  localparam logic [TOL_W-1:0]  TOLERANCE_RST  = 15'd209;
  localparam logic [RATE_W-1:0] TURN_RATE_RST  = 10'd314;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } hdtc_op_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_TURN_ANGLE = 2'd0,
    REG_TOLERANCE  = 2'd1,
    REG_TURN_RATE  = 2'd2
  } hdtc_reg_e;

  typedef enum logic [1:0] {
    MUL_WZ = 2'd0,
    MUL_XY = 2'd1,
    MUL_YY = 2'd2,
    MUL_ZZ = 2'd3
  } hdtc_mul_e;

  typedef struct packed {
    logic              load;
    hdtc_mul_e         mul_sel;
    logic              acc_en;
    hdtc_mul_e         acc_sel;
    logic              prep;
    logic              iter;
    logic [STEP_W-1:0] step;
    logic              hd_write;
    logic              tgt_write;
    logic              out_load;
    logic              out_stop;
  } hdtc_cmd_t;

  typedef struct packed {
    logic in_tol;
  } hdtc_sts_t;

  typedef struct packed {
    logic have_initial;
    logic turning;
    logic finished;
  } hdtc_flags_t;

  // atan(2^-i) in 2^32 units per turn, rounded to nearest
  function automatic logic [ANG_W-1:0] atan_lut(input logic [4:0] i);
    logic [ANG_W-1:0] r;
    case (i)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051E;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2F;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2FA;
      5'd15:   r = 32'h0000_517D;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A30;
      5'd19:   r = 32'h0000_0518;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/hdtc_datapath.sv =====
// Datapath: quaternion products, vectoring CORDIC, heading registers, settings and result item.
`timescale 1ns / 1ps

module hdtc_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [hdtc_pkg::CIDX_W-1:0]           cfg_idx_i,
  input  logic [hdtc_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic signed [hdtc_pkg::QW-1:0]        quat_w_i,
  input  logic signed [hdtc_pkg::QW-1:0]        quat_x_i,
  input  logic signed [hdtc_pkg::QW-1:0]        quat_y_i,
  input  logic signed [hdtc_pkg::QW-1:0]        quat_z_i,
  input  hdtc_pkg::hdtc_cmd_t                   cmd_i,
  output hdtc_pkg::hdtc_sts_t                   sts_o,
  output logic signed [hdtc_pkg::ORATE_W-1:0]   angular_rate_o,
  output logic                                  done_res_o
);

  localparam int XW     = hdtc_pkg::XW;
  localparam int ACC_W  = hdtc_pkg::ACC_W;
  localparam int PROD_W = hdtc_pkg::PROD_W;
  localparam int ANG_W  = hdtc_pkg::ANG_W;
  localparam int HD_W   = hdtc_pkg::HD_W;

  logic [HD_W-1:0]                   turn_angle_q;
  logic [hdtc_pkg::TOL_W-1:0]        tolerance_q;
  logic [hdtc_pkg::RATE_W-1:0]       turn_rate_q;

  logic signed [hdtc_pkg::QW-1:0]    qw_q, qx_q, qy_q, qz_q;
  logic signed [hdtc_pkg::QW-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]          prod_d, prod_q;
  logic signed [ACC_W-1:0]           prod_ext;
  logic signed [ACC_W-1:0]           num_acc_q, sq_acc_q;

  logic signed [XW-1:0]              num_p, den_p;
  logic signed [XW-1:0]              x_q, y_q, dx, dy;
  logic [ANG_W-1:0]                  ang_q, ang_rnd, atan_v;
  logic                              zero_q, zero_d, y_pos;

  logic [HD_W-1:0]                   cur_q, tgt_q, hd_new, err, mag;
  logic                              err_pos;
  logic signed [hdtc_pkg::ORATE_W-1:0] rate_pos, rate_out_q;
  logic                              done_q;

  localparam logic signed [XW-1:0] ONE_Q28 = {{(XW-29){1'b0}}, 1'b1, 28'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_angle_q <= hdtc_pkg::TURN_ANGLE_RST;
      tolerance_q  <= hdtc_pkg::TOLERANCE_RST;
      turn_rate_q  <= hdtc_pkg::TURN_RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hdtc_pkg::REG_TURN_ANGLE: turn_angle_q <= cfg_data_i;
        hdtc_pkg::REG_TOLERANCE:  tolerance_q  <= cfg_data_i[hdtc_pkg::TOL_W-1:0];
        hdtc_pkg::REG_TURN_RATE:  turn_rate_q  <= cfg_data_i[hdtc_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      hdtc_pkg::MUL_WZ: begin mul_a = qw_q; mul_b = qz_q; end
      hdtc_pkg::MUL_XY: begin mul_a = qx_q; mul_b = qy_q; end
      hdtc_pkg::MUL_YY: begin mul_a = qy_q; mul_b = qy_q; end
      hdtc_pkg::MUL_ZZ: begin mul_a = qz_q; mul_b = qz_q; end
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // num = 2(wz+xy), den = 1.0 - 2(yy+zz), both Q9.28
  assign num_p  = {{(XW-ACC_W-1){num_acc_q[ACC_W-1]}}, num_acc_q, 1'b0};
  assign den_p  = ONE_Q28 - {{(XW-ACC_W-1){sq_acc_q[ACC_W-1]}}, sq_acc_q, 1'b0};
  assign zero_d = (num_p == '0) && (den_p == '0);

  assign dx     = y_q >>> cmd_i.step;
  assign dy     = x_q >>> cmd_i.step;
  assign y_pos  = !y_q[XW-1] && (y_q != '0);
  assign atan_v = hdtc_pkg::atan_lut(5'(cmd_i.step));

  assign ang_rnd = ang_q + 32'h0000_8000;
  assign hd_new  = zero_q ? '0 : ang_rnd[ANG_W-1:ANG_W-HD_W];

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load) begin
      qw_q      <= quat_w_i;
      qx_q      <= quat_x_i;
      qy_q      <= quat_y_i;
      qz_q      <= quat_z_i;
      num_acc_q <= '0;
      sq_acc_q  <= '0;
    end else if (cmd_i.acc_en) begin
      if (cmd_i.acc_sel == hdtc_pkg::MUL_WZ || cmd_i.acc_sel == hdtc_pkg::MUL_XY) begin
        num_acc_q <= num_acc_q + prod_ext;
      end else begin
        sq_acc_q <= sq_acc_q + prod_ext;
      end
    end
    if (cmd_i.prep) begin
      zero_q <= zero_d;
      if (den_p[XW-1]) begin
        x_q   <= -den_p;
        y_q   <= -num_p;
        ang_q <= 32'h8000_0000;
      end else begin
        x_q   <= den_p;
        y_q   <= num_p;
        ang_q <= '0;
      end
    end else if (cmd_i.iter) begin
      if (y_pos) begin
        x_q   <= x_q + dx;
        y_q   <= y_q - dy;
        ang_q <= ang_q + atan_v;
      end else begin
        x_q   <= x_q - dx;
        y_q   <= y_q + dy;
        ang_q <= ang_q - atan_v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      tgt_q <= '0;
    end else begin
      if (cmd_i.hd_write) begin
        cur_q <= hd_new;
      end
      if (cmd_i.tgt_write) begin
        tgt_q <= hd_new + turn_angle_q;
      end
    end
  end

  // wrapped error, read as signed
  assign err          = tgt_q - cur_q;
  assign mag          = err[HD_W-1] ? (16'd0 - err) : err;
  assign err_pos      = !err[HD_W-1] && (err != '0);
  assign sts_o.in_tol = mag < {1'b0, tolerance_q};
  assign rate_pos     = {1'b0, turn_rate_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_stop) begin
        rate_out_q <= '0;
        done_q     <= 1'b1;
      end else begin
        rate_out_q <= err_pos ? rate_pos : -rate_pos;
        done_q     <= 1'b0;
      end
    end
  end

  assign angular_rate_o = rate_out_q;
  assign done_res_o     = done_q;

endmodule

// ===== src/hdtc_ctrl.sv =====
// Controller: item sequencing, CORDIC step count, turn flags and output valid.
`timescale 1ns / 1ps

module hdtc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  opcode_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  hdtc_pkg::hdtc_sts_t   sts_i,
  output hdtc_pkg::hdtc_cmd_t   cmd_o,
  output hdtc_pkg::hdtc_flags_t flags_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_ITER,
    ST_FIN,
    ST_TICK
  } state_e;

  localparam int CNT_W = hdtc_pkg::CNT_W;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               out_valid_q;
  logic               have_initial_q, turning_q, finished_q;
  logic               accept, out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      out_valid_q    <= 1'b0;
      have_initial_q <= 1'b0;
      turning_q      <= 1'b0;
      finished_q     <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (accept) begin
            state_q <= (opcode_i == hdtc_pkg::OP_SAMPLE) ? ST_MUL : ST_TICK;
          end
        end
        ST_MUL: begin
          if (cnt_q == CNT_W'(hdtc_pkg::MUL_LAST)) begin
            cnt_q   <= '0;
            state_q <= ST_PREP;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_PREP: begin
          cnt_q   <= '0;
          state_q <= ST_ITER;
        end
        ST_ITER: begin
          if (cnt_q == CNT_W'(hdtc_pkg::CORDIC_STEPS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_FIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FIN: begin
          have_initial_q <= 1'b1;
          state_q        <= ST_IDLE;
        end
        ST_TICK: begin
          if (out_free) begin
            if (turning_q) begin
              out_valid_q <= 1'b1;
              if (sts_i.in_tol) begin
                turning_q  <= 1'b0;
                finished_q <= 1'b1;
              end
            end else if (have_initial_q && !finished_q) begin
              turning_q <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.mul_sel   = hdtc_pkg::hdtc_mul_e'(cnt_q[1:0]);
    cmd_o.acc_en    = (state_q == ST_MUL) && (cnt_q != '0);
    cmd_o.acc_sel   = hdtc_pkg::hdtc_mul_e'(cnt_q[1:0] - 2'd1);
    cmd_o.prep      = (state_q == ST_PREP);
    cmd_o.iter      = (state_q == ST_ITER);
    cmd_o.step      = cnt_q[hdtc_pkg::STEP_W-1:0];
    cmd_o.hd_write  = (state_q == ST_FIN);
    cmd_o.tgt_write = (state_q == ST_FIN) && !have_initial_q;
    cmd_o.out_load  = (state_q == ST_TICK) && out_free && turning_q;
    cmd_o.out_stop  = sts_i.in_tol;
  end

  assign out_valid_o          = out_valid_q;
  assign flags_o.have_initial = have_initial_q;
  assign flags_o.turning      = turning_q;
  assign flags_o.finished     = finished_q;

endmodule

// ===== src/imu_heading_turn_controller.sv =====
// Top level of the quaternion yaw heading turn controller.
//
//   channel | handshake                     | payload
//   --------+-------------------------------+--------------------------------------
//   in      | in_valid_i / in_stall_o       | opcode_i, quat_w_i .. quat_z_i
//   out     | out_valid_o / out_stall_i     | angular_rate_o, done_res_o
//   cfg     | cfg_we_i                      | cfg_idx_i, cfg_data_i
//
// A sample item runs its products on the shared 16x16 multiplier, then forms the
// vector, steps through the 14 CORDIC iterations and writes the heading.
// A tick item waits in the tick state while the output register is held by a stall.
// One item at a time; in_stall_o is high until the item is finished.
// Reset is asynchronous, active low, clears flags and headings and restores default settings.
`timescale 1ns / 1ps

module imu_heading_turn_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hdtc_pkg::CIDX_W-1:0]         cfg_idx_i,
  input  logic [hdtc_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic signed [hdtc_pkg::QW-1:0]      quat_w_i,
  input  logic signed [hdtc_pkg::QW-1:0]      quat_x_i,
  input  logic signed [hdtc_pkg::QW-1:0]      quat_y_i,
  input  logic signed [hdtc_pkg::QW-1:0]      quat_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [hdtc_pkg::ORATE_W-1:0] angular_rate_o,
  output logic                                done_res_o
);

  hdtc_pkg::hdtc_cmd_t   cmd;
  hdtc_pkg::hdtc_sts_t   sts;
  hdtc_pkg::hdtc_flags_t flags;

  hdtc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .flags_o     (flags)
  );

  hdtc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .quat_w_i       (quat_w_i),
    .quat_x_i       (quat_x_i),
    .quat_y_i       (quat_y_i),
    .quat_z_i       (quat_z_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .angular_rate_o (angular_rate_o),
    .done_res_o     (done_res_o)
  );

`ifndef SYNTHESIS
  a_done_zero_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> angular_rate_o == '0)
    else $error("stop item with non-zero rate");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(flags.turning && flags.finished))
    else $error("turning and finished both set");

  a_out_needs_heading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> flags.have_initial)
    else $error("result item before any sample");

  a_done_sets_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> flags.finished && !flags.turning)
    else $error("stop item without finished flag");
`endif

endmodule

// ===== sim/imu_heading_turn_controller_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the heading turn controller: directed and random items against a yaw predictor.

module imu_heading_turn_controller_test;
  import hdtc_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 3000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int ITEMS_PER_PHASE = 120;

  // arctangent of 2^-i, 2^32 units per turn
  localparam logic [ANG_W-1:0] ATAN_TURNS [20] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
    32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518
  };

  typedef struct packed {
    logic signed [ORATE_W-1:0] rate;
    logic                      done;
  } turn_cmd_t;

  class turn_command_board;
    logic [HD_W-1:0]   turn_angle;
    logic [TOL_W-1:0]  tolerance;
    logic [RATE_W-1:0] turn_rate;
    logic [HD_W-1:0]   heading;
    logic [HD_W-1:0]   target;
    logic              have_initial;
    logic              turning;
    logic              finished;
    turn_cmd_t         pending[$];
    int                errors;

    function new();
      turn_angle   = TURN_ANGLE_RST;
      tolerance    = TOLERANCE_RST;
      turn_rate    = TURN_RATE_RST;
      heading      = '0;
      target       = '0;
      have_initial = 1'b0;
      turning      = 1'b0;
      finished     = 1'b0;
      errors       = 0;
    endfunction

    function void set_reg(hdtc_reg_e idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_TURN_ANGLE: turn_angle = val[HD_W-1:0];
        REG_TOLERANCE:  tolerance  = val[TOL_W-1:0];
        REG_TURN_RATE:  turn_rate  = val[RATE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [HD_W-1:0] yaw_of(longint w, longint x, longint y, longint z);
      longint           num;
      longint           den;
      longint           dx;
      longint           dy;
      logic [ANG_W-1:0] ang;
      int               i;
      num = 2 * (w * z + x * y);
      den = (longint'(1) << 28) - 2 * (y * y + z * z);
      ang = '0;
      if (num == 0 && den == 0) return '0;
      // left half plane: rotate by pi first
      if (den < 0) begin
        den = -den;
        num = -num;
        ang = 32'h8000_0000;
      end
      for (i = 0; i < CORDIC_STEPS && i < 20; i++) begin
        dx = num >>> i;
        dy = den >>> i;
        if (num > 0) begin
          den += dx;
          num -= dy;
          ang += ATAN_TURNS[i];
        end else begin
          den -= dx;
          num += dy;
          ang -= ATAN_TURNS[i];
        end
      end
      ang = ang + 32'h0000_8000;
      return ang[ANG_W-1:ANG_W-HD_W];
    endfunction

    function void note_item(hdtc_op_e op, logic signed [QW-1:0] w, logic signed [QW-1:0] x,
                            logic signed [QW-1:0] y, logic signed [QW-1:0] z);
      logic [HD_W-1:0] e;
      int              err;
      int              mag;
      turn_cmd_t       cmd;
      if (op == OP_SAMPLE) begin
        heading = yaw_of(w, x, y, z);
        if (!have_initial) begin
          target       = heading + turn_angle;
          have_initial = 1'b1;
        end
        return;
      end
      if (have_initial && !turning && !finished) begin
        turning = 1'b1;
        return;
      end
      if (!turning) return;
      e   = target - heading;
      err = int'(signed'(e));
      mag = (err < 0) ? -err : err;
      if (mag < int'(tolerance)) begin
        turning  = 1'b0;
        finished = 1'b1;
        cmd.rate = '0;
        cmd.done = 1'b1;
      end else begin
        cmd.rate = (err > 0) ? $signed({1'b0, turn_rate}) : -$signed({1'b0, turn_rate});
        cmd.done = 1'b0;
      end
      pending.push_back(cmd);
    endfunction

    function void check_cmd(logic signed [ORATE_W-1:0] rate, logic done);
      turn_cmd_t want;
      if (pending.size() == 0) begin
        $error("unexpected item: angular_rate %0d done_res %0d", rate, done);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (rate !== want.rate) begin
        $error("angular_rate: expected %0d, got %0d", want.rate, rate);
        errors++;
      end
      if (done !== want.done) begin
        $error("done_res: expected %0d, got %0d", want.done, done);
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        cfg_we_i       = 1'b0;
  logic [CIDX_W-1:0]           cfg_idx_i      = '0;
  logic [CFG_W-1:0]            cfg_data_i     = '0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_stall_o;
  logic                        opcode_i       = 1'b0;
  logic signed [QW-1:0]        quat_w_i       = '0;
  logic signed [QW-1:0]        quat_x_i       = '0;
  logic signed [QW-1:0]        quat_y_i       = '0;
  logic signed [QW-1:0]        quat_z_i       = '0;
  logic                        out_valid_o;
  logic                        out_stall_i    = 1'b0;
  logic signed [ORATE_W-1:0]   angular_rate_o;
  logic                        done_res_o;

  turn_command_board board = new();

  int sender_idle_pct = 26;
  int recv_stall_pct  = 65;
  int hold_req        = 0;
  int hold_left       = 0;
  int quiet_cycles    = 0;

  imu_heading_turn_controller dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) board.check_cmd(angular_rate_o, done_res_o);
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic signed [QW-1:0] rand_comp();
    return QW'(int'($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic signed [QW-1:0] rand_extreme();
    return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
  endfunction

  task automatic send_item(hdtc_op_e op, logic signed [QW-1:0] w, logic signed [QW-1:0] x,
                           logic signed [QW-1:0] y, logic signed [QW-1:0] z);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    quat_w_i   <= w;
    quat_x_i   <= x;
    quat_y_i   <= y;
    quat_z_i   <= z;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(op, w, x, y, z);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  task automatic send_pair(logic signed [QW-1:0] w, logic signed [QW-1:0] x,
                           logic signed [QW-1:0] y, logic signed [QW-1:0] z);
    send_item(OP_SAMPLE, w, x, y, z);
    send_tick();
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(hdtc_reg_e idx, logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    board.set_reg(idx, val);
  endtask

  // a sample in flight gives no result, so let it settle before writing
  task automatic reconfigure(logic [CFG_W-1:0] angle, logic [CFG_W-1:0] tol,
                             logic [CFG_W-1:0] rate);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_TURN_ANGLE, angle);
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_TURN_RATE, rate);
  endtask

  task automatic send_random(int count, int pause_at);
    int n;
    int pick;
    for (n = 0; n < count; n++) begin
      if (n == pause_at) drain_results();
      pick = $urandom_range(19);
      if (pick < 9) begin
        send_tick();
      end else if (pick == 9) begin
        case ($urandom_range(3))
          0: send_item(OP_SAMPLE, 16'sd0, 16'sd0, 16'sd8192, 16'sd8192);
          1: send_item(OP_SAMPLE, 16'sd0, 16'sd0, 16'sd0, rand_extreme());
          2: send_item(OP_SAMPLE, rand_extreme(), rand_extreme(), rand_extreme(),
                       rand_extreme());
          default: send_item(OP_SAMPLE, rand_extreme(), 16'sd0, 16'sd0, 16'sd0);
        endcase
      end else begin
        send_item(OP_SAMPLE, rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick before any sample
    send_tick();
    reconfigure(16'd0, 16'd0, 16'd1000);
    // zero vector as first sample: yaw 0, target 0
    send_item(OP_SAMPLE, 16'sd0, 16'sd0, 16'sd8192, 16'sd8192);
    send_tick();
    // zero error, then an error of pi: both negative
    send_tick();
    send_pair(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    send_pair(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    send_pair(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
    send_pair(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_pair(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    send_pair(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_pair(16'sd0, 16'sd0, 16'sd0, -16'sd16384);
    send_pair(-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384);
    send_pair(16'sd0, -16'sd1, 16'sd1, 16'sd0);

    reconfigure(16'hFFFF, 16'd0, 16'd1023);
    send_random(ITEMS_PER_PHASE, ITEMS_PER_PHASE / 2);

    sender_idle_pct = 65;
    recv_stall_pct  = 26;
    reconfigure(16'($urandom), 16'd0, 16'($urandom_range(1, 999)));
    send_random(ITEMS_PER_PHASE, -1);

    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    reconfigure(16'd0, 16'd0, 16'd0);
    hold_req = HOLD_OFF_CYCLES;
    send_random(ITEMS_PER_PHASE, -1);

    // moderate tolerance: the turn completes somewhere in here
    reconfigure(16'($urandom), 16'd4096, 16'($urandom_range(1, 1000)));
    send_random(60, -1);

    reconfigure(16'h8000, 16'd32767, 16'($urandom_range(1023)));
    send_random(20, -1);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
